[rtl/sad_pkg.sv]
// Shared types, constants and the arctangent table for the steering angle and distance core.
// Used by every file of the block; depends on nothing.
package sad_pkg;

  // Field widths of the words on the two channels.
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned ANGLE_W    = ANGLE_BITS + 1;
  localparam int unsigned DIST_W     = 17;

  // Coordinate difference, and the difference after mirroring (one more bit).
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned VEC_W  = DIFF_W + 1;

  // CORDIC datapath: vector prescaled by 2^24, plus headroom for the gain.
  localparam int unsigned FRAC_SHIFT = 24;
  localparam int unsigned XY_W       = VEC_W + FRAC_SHIFT + 4;
  localparam int unsigned Z_W        = 32;

  // Square root datapath: sum of squares, root digits and partial remainder.
  localparam int unsigned SUM_W  = 2 * COORD_W + 2;
  localparam int unsigned ROOT_W = SUM_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned STEP_W = $clog2(ROOT_W);

  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(92682);

  // Fractions of a turn, 2^32 being one full turn.
  localparam logic [Z_W-1:0] TURN_ZERO    = 32'h0000_0000;
  localparam logic [Z_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [Z_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [Z_W-1:0] TURN_3QUART  = 32'hC000_0000;

  // Steering direction codes.
  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic                      direction;
  } in_word_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic        [DIST_W-1:0]  distance;
  } out_word_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_SQ_X,
    DP_SQ_Y,
    DP_ROOT,
    DP_ROUND
  } dist_phase_e;

  // Micro-rotation angle atan(2^-i) as a fraction of a turn, 2^32 per turn.
  function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] idx);
    logic [Z_W-1:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      5'd24:   val = 32'd41;
      5'd25:   val = 32'd20;
      5'd26:   val = 32'd10;
      5'd27:   val = 32'd5;
      5'd28:   val = 32'd3;
      5'd29:   val = 32'd1;
      5'd30:   val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

[rtl/sad_if.sv]
// Valid/ready channel interfaces for the input and result words.
// Depends on sad_pkg for the word types.
interface sad_in_if;
  logic              valid;
  logic              ready;
  sad_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sad_out_if;
  logic               valid;
  logic               ready;
  sad_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sad_cordic.sv]
// Iterative CORDIC vectoring unit: one micro-rotation per cycle on a shared add/shift datapath.
// Depends on sad_pkg for widths, turn constants and the arctangent table.
module sad_cordic #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [sad_pkg::VEC_W-1:0] dx_i,
  input  logic signed [sad_pkg::VEC_W-1:0] dy_i,
  output logic                             busy_o,
  output logic        [sad_pkg::Z_W-1:0]   z_o
);

  localparam int unsigned CNT_W = $clog2(ITERATIONS);
  localparam int unsigned PAD_W = sad_pkg::XY_W - sad_pkg::VEC_W - sad_pkg::FRAC_SHIFT;

  logic                            busy_q, busy_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic signed [sad_pkg::XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [sad_pkg::XY_W-1:0] xs, ys;
  logic        [sad_pkg::Z_W-1:0]  z_q, z_d, step_angle;
  logic signed [sad_pkg::VEC_W-1:0] fx, fy;
  logic                            y_pos;

  // Fold the left half-plane onto the right one by a half turn.
  always_comb begin
    fx = dx_i;
    fy = dy_i;
    if (dx_i[sad_pkg::VEC_W-1]) begin
      fx = -dx_i;
      fy = -dy_i;
    end
  end

  // Shared micro-rotation datapath.
  assign xs         = x_q >>> cnt_q;
  assign ys         = y_q >>> cnt_q;
  assign y_pos      = !y_q[sad_pkg::XY_W-1] && (y_q != '0);
  assign step_angle = sad_pkg::atan_turn(5'(cnt_q));

  // Sequencer for the rotation count and the vector/angle registers.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      cnt_d = '0;
      x_d   = {{PAD_W{fx[sad_pkg::VEC_W-1]}}, fx, {sad_pkg::FRAC_SHIFT{1'b0}}};
      y_d   = {{PAD_W{fy[sad_pkg::VEC_W-1]}}, fy, {sad_pkg::FRAC_SHIFT{1'b0}}};
      if (dx_i == '0) begin
        // Vertical vector: up is a quarter turn, anything else three quarters.
        busy_d = 1'b0;
        z_d    = (!dy_i[sad_pkg::VEC_W-1] && (dy_i != '0)) ? sad_pkg::TURN_QUARTER
                                                             : sad_pkg::TURN_3QUART;
      end else if (dy_i == '0) begin
        // Horizontal vector: exactly zero or half a turn.
        busy_d = 1'b0;
        z_d    = dx_i[sad_pkg::VEC_W-1] ? sad_pkg::TURN_HALF : sad_pkg::TURN_ZERO;
      end else begin
        busy_d = 1'b1;
        z_d    = dx_i[sad_pkg::VEC_W-1] ? sad_pkg::TURN_HALF : sad_pkg::TURN_ZERO;
      end
    end else if (busy_q) begin
      if (y_pos) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + step_angle;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - step_angle;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ITERATIONS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign busy_o = busy_q;
  assign z_o    = z_q;

endmodule

[rtl/sad_dist.sv]
// Distance unit: squares through one shared multiplier, then a digit-by-digit square root
// with round-to-nearest and saturation. Depends on sad_pkg for widths and phase codes.
module sad_dist (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [sad_pkg::DIFF_W-1:0] dx_i,
  input  logic signed [sad_pkg::DIFF_W-1:0] dy_i,
  output logic                              busy_o,
  output logic        [sad_pkg::DIST_W-1:0] dist_o
);

  sad_pkg::dist_phase_e phase_q, phase_d;

  logic [sad_pkg::STEP_W-1:0]  step_q, step_d;
  logic [sad_pkg::COORD_W-1:0] ax_q, ay_q, ax, ay, mul_op;
  logic [2*sad_pkg::COORD_W-1:0] prod;
  logic [sad_pkg::SUM_W-1:0]   s_q, s_d;
  logic [sad_pkg::ROOT_W-1:0]  root_q, root_d;
  logic [sad_pkg::REM_W-1:0]   rem_q, rem_d, rem_sh, trial;
  logic [sad_pkg::ROOT_W:0]    rounded;
  logic [sad_pkg::DIST_W-1:0]  dist_q, dist_d;
  logic signed [sad_pkg::DIFF_W-1:0] dx_abs, dy_abs;

  // Magnitudes fit the coordinate width since a difference never reaches -2^16.
  assign dx_abs = dx_i[sad_pkg::DIFF_W-1] ? -dx_i : dx_i;
  assign dy_abs = dy_i[sad_pkg::DIFF_W-1] ? -dy_i : dy_i;
  assign ax     = dx_abs[sad_pkg::COORD_W-1:0];
  assign ay     = dy_abs[sad_pkg::COORD_W-1:0];

  // One multiplier, shared by the two squares.
  assign mul_op = (phase_q == sad_pkg::DP_SQ_X) ? ax_q : ay_q;
  assign prod   = mul_op * mul_op;

  // One root digit: bring down two bits and try to subtract 4*root + 1.
  assign rem_sh  = {rem_q[sad_pkg::REM_W-3:0], s_q[sad_pkg::SUM_W-1 -: 2]};
  assign trial   = sad_pkg::REM_W'({root_q, 2'b01});
  assign rounded = {1'b0, root_q} + (sad_pkg::ROOT_W + 1)'(rem_q > sad_pkg::REM_W'(root_q));

  // Phase sequencer.
  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    s_d     = s_q;
    root_d  = root_q;
    rem_d   = rem_q;
    dist_d  = dist_q;
    case (phase_q)
      sad_pkg::DP_IDLE: begin
        if (start_i) begin
          phase_d = sad_pkg::DP_SQ_X;
        end
      end
      sad_pkg::DP_SQ_X: begin
        s_d     = sad_pkg::SUM_W'(prod);
        phase_d = sad_pkg::DP_SQ_Y;
      end
      sad_pkg::DP_SQ_Y: begin
        s_d     = s_q + sad_pkg::SUM_W'(prod);
        step_d  = '0;
        root_d  = '0;
        rem_d   = '0;
        phase_d = sad_pkg::DP_ROOT;
      end
      sad_pkg::DP_ROOT: begin
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[sad_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[sad_pkg::ROOT_W-2:0], 1'b0};
        end
        s_d    = s_q << 2;
        step_d = step_q + 1'b1;
        if (step_q == sad_pkg::STEP_W'(sad_pkg::ROOT_W - 1)) begin
          phase_d = sad_pkg::DP_ROUND;
        end
      end
      sad_pkg::DP_ROUND: begin
        // Round up when the remainder exceeds the root, then saturate.
        if (rounded > (sad_pkg::ROOT_W + 1)'(sad_pkg::DIST_MAX)) begin
          dist_d = sad_pkg::DIST_MAX;
        end else begin
          dist_d = rounded[sad_pkg::DIST_W-1:0];
        end
        phase_d = sad_pkg::DP_IDLE;
      end
      default: begin
        phase_d = sad_pkg::DP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sad_pkg::DP_IDLE;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (phase_q == sad_pkg::DP_IDLE)) begin
      ax_q <= ax;
      ay_q <= ay;
    end
    s_q    <= s_d;
    root_q <= root_d;
    rem_q  <= rem_d;
    dist_q <= dist_d;
  end

  assign busy_o = (phase_q != sad_pkg::DP_IDLE);
  assign dist_o = dist_q;

endmodule

[rtl/steering_angle_and_distance_core.sv]
// Top level: input capture, sequencer, angle rounding and output register.
// Depends on sad_pkg, sad_if, sad_cordic and sad_dist.
//
//   channel  | role   | word
//   ---------+--------+--------------------------------------------------
//   in_i     | sink   | origin_x, origin_y, target_x, target_y, direction
//   out_o    | source | angle, distance
//
// A new word is accepted only while the sequencer is idle, once both units are done with
// the last: the distance unit squares both differences on the multiplier, finds 17 root
// digits and rounds, while the CORDIC unit runs ITERATIONS micro-rotations beside it.
// The result sits in an output register, so a new word is taken while it waits.
// If the output register is still full when both units finish, the block holds there.
// Reset is asynchronous and active low; it clears the sequencer and the output valid.
module steering_angle_and_distance_core #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sad_in_if.sink            in_i,
  sad_out_if.source         out_o
);

  sad_pkg::seq_state_e state_q, state_d;

  logic                               in_fire, out_free, load_out;
  logic                               dir_q;
  logic                               out_valid_q, out_valid_d;
  sad_pkg::out_word_t                 out_q;
  logic signed [sad_pkg::DIFF_W-1:0]  dx, dy;
  logic signed [sad_pkg::VEC_W-1:0]   cdx, cdy, dx_ext;
  logic                               cordic_busy, dist_busy;
  logic        [sad_pkg::Z_W-1:0]     z;
  logic        [sad_pkg::DIST_W-1:0]  dist_value;
  logic        [sad_pkg::ANGLE_BITS-1:0] angle_round;
  logic        [sad_pkg::ANGLE_W-1:0] angle_left, angle_out;

  // Coordinate differences; right steering mirrors x.
  assign dx     = {in_i.data.target_x[sad_pkg::COORD_W-1], in_i.data.target_x}
                - {in_i.data.origin_x[sad_pkg::COORD_W-1], in_i.data.origin_x};
  assign dy     = {in_i.data.target_y[sad_pkg::COORD_W-1], in_i.data.target_y}
                - {in_i.data.origin_y[sad_pkg::COORD_W-1], in_i.data.origin_y};
  assign dx_ext = {dx[sad_pkg::DIFF_W-1], dx};
  assign cdx    = (in_i.data.direction == sad_pkg::DIR_RIGHT) ? -dx_ext : dx_ext;
  assign cdy    = {dy[sad_pkg::DIFF_W-1], dy};

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  sad_cordic #(
    .ITERATIONS(ITERATIONS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_fire),
    .dx_i   (cdx),
    .dy_i   (cdy),
    .busy_o (cordic_busy),
    .z_o    (z)
  );

  sad_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_fire),
    .dx_i   (dx),
    .dy_i   (dy),
    .busy_o (dist_busy),
    .dist_o (dist_value)
  );

  // Round the turn fraction half-up to ANGLE_BITS bits, zero-extend, negate for right.
  assign angle_round = z[sad_pkg::Z_W-1 -: sad_pkg::ANGLE_BITS]
                     + sad_pkg::ANGLE_BITS'(z[sad_pkg::Z_W-1-sad_pkg::ANGLE_BITS]);
  assign angle_left  = {1'b0, angle_round};
  assign angle_out   = (dir_q == sad_pkg::DIR_RIGHT) ? -angle_left : angle_left;

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_d     = state_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      sad_pkg::SEQ_IDLE: begin
        if (in_fire) begin
          state_d = sad_pkg::SEQ_RUN;
        end
      end
      sad_pkg::SEQ_RUN: begin
        if (!cordic_busy && !dist_busy && out_free) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = sad_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = sad_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sad_pkg::SEQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dir_q <= in_i.data.direction;
    end
    if (load_out) begin
      out_q.angle    <= angle_out;
      out_q.distance <= dist_value;
    end
  end

  assign in_i.ready  = (state_q == sad_pkg::SEQ_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // An accepted word always starts a run.
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == sad_pkg::SEQ_RUN))
    else $error("accepted word did not start a run");

  // While waiting for a word, neither unit may still be computing.
  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sad_pkg::SEQ_IDLE) |-> (!cordic_busy && !dist_busy))
    else $error("unit busy while sequencer idle");

  // A new result only appears at the end of a run.
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sad_pkg::SEQ_RUN))
    else $error("result raised outside a run");

  // The distance shown never exceeds its saturation value.
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.distance <= sad_pkg::DIST_MAX))
    else $error("distance above saturation value");

endmodule
